// ----- hw/rtl/dltm_pkg.sv -----
package dltm_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_NUM_TIMERS  = 8;
	localparam int DEF_COUNT_WIDTH = 32;

	// Most expiry results reported by one tick
	localparam int RESULT_CAP = 8;
	localparam int CAP_W      = $clog2(RESULT_CAP + 1);

	// Field widths on the stream ports
	localparam int CMD_W     = 3;
	localparam int PORT_ID_W = 3;
	localparam int PORT_CW   = 32;
	localparam int S_DATA_W  = 72;
	localparam int M_DATA_W  = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 3'd0,
		CMD_START  = 3'd1,
		CMD_STOP   = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_SET    = 3'd4,
		CMD_READ   = 3'd5,
		CMD_TICK   = 3'd6
	} cmd_t;

	// What each cell of the order chain does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_SHL  = 2'd1,
		CELL_INS  = 2'd2
	} cell_op_t;

endpackage

// ----- hw/rtl/dltm_cell.sv -----
module dltm_cell import dltm_pkg::*; #(
	parameter int IW = 3,
	parameter int LW = 4,
	parameter int IDX = 0,
	parameter type ctrl_t = logic
) (
	input  logic          clk,
	input  ctrl_t         ctrl,
	input  logic [IW-1:0] left_id,
	input  logic [IW-1:0] right_id,
	output logic [IW-1:0] slot_id,
	output logic          hit
);

	logic [IW-1:0] slot_q;

	// Shift toward the head on removal, away from it on insertion
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_SHL: begin
				if (IW'(IDX) >= ctrl.pos) slot_q <= right_id;
			end
			CELL_INS: begin
				if (IW'(IDX) > ctrl.pos) slot_q <= left_id;
				else if (IW'(IDX) == ctrl.pos) slot_q <= ctrl.new_id;
			end
			default: begin
			end
		endcase
	end

	// Only slots inside the list length take part in the search
	assign hit     = (LW'(IDX) < ctrl.len) && (slot_q == ctrl.tgt);
	assign slot_id = slot_q;

endmodule

// ----- hw/rtl/delta_list_timer_manager.sv -----
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  one command transaction, s_tuser = command
// m_*      out  m_tvalid/m_tready  result transactions, m_tlast on the final one
//
// One command at a time. An insert walks the order chain one listed timer at a
// time through the single read port of the count memory. Reset clears the state
// machine, the timer flags, the list length and the count valid bits; there is no
// clearing pass. A stalled m_tready holds the sequencer only where it has a result
// to hand over.
module delta_list_timer_manager import dltm_pkg::*; #(
	parameter int NUM_TIMERS  = DEF_NUM_TIMERS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [2:0] timer_id, [3] timer_kind, [35:4] count_value, [67:36] reload_value
	input  logic [S_DATA_W-1:0] s_tdata,
	// [2:0] command
	input  logic [CMD_W-1:0]    s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [0] status, [3:1] result_id, [4] expired, [36:5] read_count
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tlast
);

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int LW = $clog2(NUM_TIMERS + 1);

	typedef struct packed {
		cell_op_t      op;
		logic [IW-1:0] pos;
		logic [IW-1:0] new_id;
		logic [IW-1:0] tgt;
		logic [LW-1:0] len;
	} cell_ctrl_t;

	typedef enum logic [18:0] {
		S_IDLE      = 19'h00001,
		S_DISP      = 19'h00002,
		S_RD        = 19'h00004,
		S_RM_FIND   = 19'h00008,
		S_RM_RDA    = 19'h00010,
		S_RM_RDB    = 19'h00020,
		S_RM_SHIFT  = 19'h00040,
		S_AFTER     = 19'h00080,
		S_INS_START = 19'h00100,
		S_INS_LD    = 19'h00200,
		S_INS_RD    = 19'h00400,
		S_INS_CMP   = 19'h00800,
		S_INS_PUT   = 19'h01000,
		S_TK0       = 19'h02000,
		S_TK1       = 19'h04000,
		S_TK_LOOP   = 19'h08000,
		S_TK_CHK    = 19'h10000,
		S_TK_EMIT   = 19'h20000,
		S_FIN       = 19'h40000
	} state_t;

	typedef enum logic [2:0] {
		AF_DONE   = 3'd0,
		AF_STOP   = 3'd1,
		AF_DEL    = 3'd2,
		AF_SET    = 3'd3,
		AF_TK_RM  = 3'd4,
		AF_TK_INS = 3'd5
	} after_t;

	state_t                 state_q;
	after_t                 after_q;
	cmd_t                   cmd_q;
	logic [IW-1:0]          idx_q;
	logic                   rng_q;
	logic                   kin_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] rld_q;
	logic [NUM_TIMERS-1:0]  alloc_q;
	logic [NUM_TIMERS-1:0]  kind_q;
	logic [NUM_TIMERS-1:0]  running_q;
	logic [NUM_TIMERS-1:0]  listed_q;
	logic [LW-1:0]          len_q;
	logic [IW-1:0]          cur_q;
	logic [IW-1:0]          p_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] tmp_q;
	logic [CAP_W-1:0]       n_q;
	logic                   pend_q;
	logic                   res_status_q;
	logic [PORT_ID_W-1:0]   res_id_q;
	logic                   res_exp_q;
	logic [COUNT_WIDTH-1:0] res_cnt_q;
	logic                   m_tvalid_q;
	logic [M_DATA_W-1:0]    m_tdata_q;
	logic                   m_tlast_q;

	// Count memory with valid bits, reload memory
	logic [COUNT_WIDTH-1:0] tick_mem [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] reload_mem [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  tvld_q;
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic                   rvld_q;
	logic [COUNT_WIDTH-1:0] reload_rd_q;
	logic [COUNT_WIDTH-1:0] rdval;
	logic [IW-1:0]          raddr;
	logic                   we;
	logic [IW-1:0]          waddr;
	logic [COUNT_WIDTH-1:0] wdata;
	logic                   rwe;
	logic [IW-1:0]          rwaddr;

	cell_ctrl_t             ctrl;
	logic [IW-1:0]          slot_w [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  hit_w;
	logic [IW-1:0]          hit_pos;
	logic                   free_found;
	logic [IW-1:0]          free_idx;
	logic                   alloc_id;
	logic                   can_push;
	logic                   push;
	logic [IW-1:0]          nxt_pos;

	assign rdval    = rvld_q ? rdata_q : '0;
	assign alloc_id = rng_q && alloc_q[idx_q];
	assign can_push = !m_tvalid_q || m_tready;
	assign nxt_pos  = p_q + IW'(1);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// A result enters the output register: the final one, or an earlier expiry
	assign push = can_push && ((state_q == S_FIN) ||
	              ((state_q == S_TK_CHK) && (rdval == '0) && pend_q));

	// Order chain
	assign ctrl.op     = (state_q == S_RM_SHIFT) ? CELL_SHL :
	                     (state_q == S_INS_PUT) ? CELL_INS : CELL_HOLD;
	assign ctrl.pos    = p_q;
	assign ctrl.new_id = cur_q;
	assign ctrl.tgt    = cur_q;
	assign ctrl.len    = len_q;

	for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
		dltm_cell #(
			.IW(IW), .LW(LW), .IDX(k), .ctrl_t(cell_ctrl_t)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.left_id(slot_w[(k == 0) ? 0 : k - 1]),
			.right_id(slot_w[(k == NUM_TIMERS - 1) ? k : k + 1]),
			.slot_id(slot_w[k]),
			.hit(hit_w[k])
		);
	end

	// Position of the one matching cell
	always_comb begin
		hit_pos = '0;
		for (int k = 0; k < NUM_TIMERS; k++)
			if (hit_w[k]) hit_pos = hit_pos | IW'(k);
	end

	// Lowest free ID
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--)
			if (!alloc_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
	end

	// Memory port selection per state
	always_comb begin
		raddr  = cur_q;
		we     = 1'b0;
		waddr  = cur_q;
		wdata  = cnt_q;
		rwe    = 1'b0;
		rwaddr = cur_q;
		case (state_q)
			S_DISP: begin
				if (cmd_q == CMD_CREATE && free_found) begin
					we     = 1'b1;
					waddr  = free_idx;
					rwe    = 1'b1;
					rwaddr = free_idx;
				end
				raddr = idx_q;
			end
			S_RM_RDA: raddr = slot_w[nxt_pos];
			S_RM_RDB: begin
				we    = 1'b1;
				waddr = slot_w[nxt_pos];
				wdata = rdval + tmp_q;
			end
			S_AFTER: begin
				if (after_q == AF_SET) begin
					we  = 1'b1;
					rwe = 1'b1;
				end else if (after_q == AF_TK_RM && kind_q[cur_q]) begin
					we    = 1'b1;
					wdata = reload_rd_q;
				end
			end
			S_INS_RD: raddr = slot_w[p_q];
			S_INS_CMP: begin
				if (rem_q < rdval) begin
					we    = 1'b1;
					waddr = slot_w[p_q];
					wdata = rdval - rem_q;
				end
			end
			S_INS_PUT: begin
				we    = 1'b1;
				wdata = rem_q;
			end
			S_TK0, S_TK_LOOP, S_TK_CHK: raddr = slot_w[0];
			S_TK1: begin
				we    = (rdval != '0);
				waddr = slot_w[0];
				wdata = rdval - COUNT_WIDTH'(1);
			end
			default: begin
			end
		endcase
	end

	// Memory arrays, registered reads
	always_ff @(posedge clk) begin
		if (we) tick_mem[waddr] <= wdata;
		if (rwe) reload_mem[rwaddr] <= rld_q;
		rdata_q     <= tick_mem[raddr];
		reload_rd_q <= reload_mem[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvld_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) tvld_q[waddr] <= 1'b1;
			rvld_q <= tvld_q[raddr] || (we && waddr == raddr);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			after_q    <= AF_DONE;
			alloc_q    <= '0;
			kind_q     <= '0;
			running_q  <= '0;
			listed_q   <= '0;
			len_q      <= '0;
			n_q        <= '0;
			pend_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q        <= cmd_t'(s_tuser);
						idx_q        <= IW'(s_tdata[2:0]);
						rng_q        <= (32'(s_tdata[2:0]) < NUM_TIMERS);
						kin_q        <= s_tdata[3];
						cnt_q        <= s_tdata[4 +: COUNT_WIDTH];
						rld_q        <= s_tdata[36 +: COUNT_WIDTH];
						res_status_q <= 1'b0;
						res_id_q     <= '0;
						res_exp_q    <= 1'b0;
						res_cnt_q    <= '0;
						n_q          <= '0;
						pend_q       <= 1'b0;
						state_q      <= S_DISP;
					end
				end
				S_DISP: begin
					cur_q   <= idx_q;
					state_q <= S_FIN;
					case (cmd_q)
						CMD_CREATE: begin
							if (free_found) begin
								alloc_q[free_idx]   <= 1'b1;
								kind_q[free_idx]    <= kin_q;
								running_q[free_idx] <= 1'b0;
								listed_q[free_idx]  <= 1'b0;
								res_id_q            <= PORT_ID_W'(free_idx);
							end else begin
								res_status_q <= 1'b1;
							end
						end
						CMD_START: begin
							if (alloc_id && !running_q[idx_q]) begin
								running_q[idx_q] <= 1'b1;
								after_q          <= AF_DONE;
								state_q          <= S_INS_START;
							end
						end
						CMD_STOP: begin
							if (alloc_id && running_q[idx_q]) begin
								after_q <= AF_STOP;
								state_q <= listed_q[idx_q] ? S_RM_FIND : S_AFTER;
							end
						end
						CMD_DELETE: begin
							if (alloc_id) begin
								after_q <= AF_DEL;
								state_q <= listed_q[idx_q] ? S_RM_FIND : S_AFTER;
							end
						end
						CMD_SET: begin
							if (alloc_id) begin
								after_q <= AF_SET;
								state_q <= (running_q[idx_q] && listed_q[idx_q]) ?
								           S_RM_FIND : S_AFTER;
							end
						end
						CMD_READ: state_q <= S_RD;
						CMD_TICK: state_q <= S_TK0;
						default:  state_q <= S_FIN;
					endcase
				end
				S_RD: begin
					res_cnt_q <= rng_q ? rdval : '0;
					state_q   <= S_FIN;
				end
				// Removal: locate, fold delta into successor, close the gap
				S_RM_FIND: begin
					if (|hit_w) begin
						p_q     <= hit_pos;
						state_q <= S_RM_RDA;
					end else begin
						listed_q[cur_q] <= 1'b0;
						state_q         <= S_AFTER;
					end
				end
				S_RM_RDA: begin
					tmp_q   <= rdval;
					state_q <= ((LW'(p_q) + LW'(1)) < len_q) ? S_RM_RDB : S_RM_SHIFT;
				end
				S_RM_RDB: state_q <= S_RM_SHIFT;
				S_RM_SHIFT: begin
					len_q           <= len_q - LW'(1);
					listed_q[cur_q] <= 1'b0;
					state_q         <= S_AFTER;
				end
				S_AFTER: begin
					case (after_q)
						AF_STOP: begin
							running_q[cur_q] <= 1'b0;
							state_q          <= S_FIN;
						end
						AF_DEL: begin
							running_q[cur_q] <= 1'b0;
							alloc_q[cur_q]   <= 1'b0;
							state_q          <= S_FIN;
						end
						AF_SET: begin
							after_q <= AF_DONE;
							state_q <= running_q[cur_q] ? S_INS_START : S_FIN;
						end
						AF_TK_RM: begin
							if (kind_q[cur_q]) begin
								after_q <= AF_TK_INS;
								state_q <= S_INS_START;
							end else begin
								running_q[cur_q] <= 1'b0;
								state_q          <= S_TK_EMIT;
							end
						end
						AF_TK_INS: state_q <= S_TK_EMIT;
						default:   state_q <= S_FIN;
					endcase
				end
				// Insertion: walk deltas until the remainder falls short
				S_INS_START: state_q <= S_INS_LD;
				S_INS_LD: begin
					rem_q <= rdval;
					p_q   <= '0;
					if (rdval == '0 || listed_q[cur_q] || len_q == LW'(NUM_TIMERS))
						state_q <= S_AFTER;
					else
						state_q <= S_INS_RD;
				end
				S_INS_RD: state_q <= (LW'(p_q) == len_q) ? S_INS_PUT : S_INS_CMP;
				S_INS_CMP: begin
					if (rem_q < rdval) begin
						state_q <= S_INS_PUT;
					end else begin
						rem_q   <= rem_q - rdval;
						p_q     <= p_q + IW'(1);
						state_q <= S_INS_RD;
					end
				end
				S_INS_PUT: begin
					len_q           <= len_q + LW'(1);
					listed_q[cur_q] <= 1'b1;
					state_q         <= S_AFTER;
				end
				// Tick: decrement head, then expire zero heads
				S_TK0: state_q <= (len_q == '0) ? S_FIN : S_TK1;
				S_TK1: state_q <= S_TK_LOOP;
				S_TK_LOOP: begin
					if (len_q == '0 || n_q == CAP_W'(RESULT_CAP)) state_q <= S_FIN;
					else state_q <= S_TK_CHK;
				end
				S_TK_CHK: begin
					if (rdval != '0) begin
						state_q <= S_FIN;
					end else if (!pend_q || can_push) begin
						if (pend_q) begin
							m_tdata_q  <= {3'b000, PORT_CW'(res_cnt_q), res_exp_q,
							               res_id_q, res_status_q};
							m_tlast_q  <= 1'b0;
						end
						cur_q   <= slot_w[0];
						after_q <= AF_TK_RM;
						state_q <= S_RM_FIND;
					end
				end
				S_TK_EMIT: begin
					res_id_q  <= PORT_ID_W'(cur_q);
					res_exp_q <= 1'b1;
					pend_q    <= 1'b1;
					n_q       <= n_q + CAP_W'(1);
					state_q   <= S_TK_LOOP;
				end
				S_FIN: begin
					if (can_push) begin
						m_tdata_q  <= {3'b000, PORT_CW'(res_cnt_q), res_exp_q,
						               res_id_q, res_status_q};
						m_tlast_q  <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// List bookkeeping checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) <= NUM_TIMERS) else $error("list length beyond pool");
	a_len_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (32'($countones(listed_q)) == 32'(len_q)))
		else $error("listed count differs from list length");
	a_listed_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((listed_q & ~running_q) == '0))
		else $error("listed timer not running");
	a_run_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(running_q & ~alloc_q) == '0) else $error("running timer not allocated");

endmodule

// ----- tb/sv/delta_list_timer_manager_test.sv -----
`timescale 1ns / 100ps

module delta_list_timer_manager_test;
	import dltm_pkg::*;

	localparam int NT = 8;

	typedef struct packed {
		logic        status;
		logic [2:0]  rid;
		logic        expired;
		logic [31:0] rcount;
		logic        last;
	} tres_t;

	typedef struct {
		cmd_t        cmd;
		logic [2:0]  id;
		logic        kind;
		logic [31:0] cnt;
		logic [31:0] rld;
		logic        chk;
		tres_t       want;
	} trow_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	logic [S_DATA_W-1:0] s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic [M_DATA_W-1:0] m_tdata;

	delta_list_timer_manager dut (.*);

	// timer pool state
	logic [NT-1:0] alloc_m, kind_m, run_m, listed_m;
	logic [31:0] cnt_m [NT];
	logic [31:0] rld_m [NT];
	logic [2:0] order_m [NT];
	int list_len;

	tres_t pending_q [$];
	int errors = 0;
	int send_idle = 7, recv_idle = 55;
	int seen_results = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("delta_list_timer_manager_test NOT OK");
		$finish;
	end

	function automatic tres_t mk(logic st, logic [2:0] rid, logic ex, logic [31:0] rc,
			logic lst);
		tres_t r;
		r.status = st; r.rid = rid; r.expired = ex; r.rcount = rc; r.last = lst;
		return r;
	endfunction

	task automatic unlink(int id);
		int p;
		if (!listed_m[id]) return;
		for (p = 0; p < list_len; p++) if (order_m[p] == id) break;
		if (p >= list_len) begin
			listed_m[id] = 0;
			return;
		end
		if (p + 1 < list_len) cnt_m[order_m[p+1]] += cnt_m[id];
		for (int k = p; k + 1 < list_len; k++) order_m[k] = order_m[k+1];
		list_len--;
		listed_m[id] = 0;
	endtask

	task automatic link(int id);
		logic [31:0] rem;
		int p;
		rem = cnt_m[id];
		if (rem == 0 || listed_m[id] || list_len >= NT) return;
		for (p = 0; p < list_len; p++) begin
			if (rem < cnt_m[order_m[p]]) begin
				cnt_m[order_m[p]] -= rem;
				break;
			end
			rem -= cnt_m[order_m[p]];
		end
		for (int k = list_len; k > p; k--) order_m[k] = order_m[k-1];
		order_m[p] = 3'(id);
		cnt_m[id] = rem;
		list_len++;
		listed_m[id] = 1;
	endtask

	// work out the results of one command and queue them
	task automatic predict_timers(cmd_t c, logic [2:0] id, logic kd, logic [31:0] cv,
			logic [31:0] rv);
		tres_t r [$];
		int i, h;
		case (c)
			CMD_CREATE: begin
				for (i = 0; i < NT; i++) if (!alloc_m[i]) break;
				if (i < NT) begin
					alloc_m[i] = 1; kind_m[i] = kd; run_m[i] = 0; listed_m[i] = 0;
					cnt_m[i] = cv; rld_m[i] = rv;
					r.push_back(mk(0, 3'(i), 0, 0, 0));
				end else r.push_back(mk(1, 0, 0, 0, 0));
			end
			CMD_START: begin
				if (alloc_m[id] && !run_m[id]) begin
					run_m[id] = 1;
					link(id);
				end
				r.push_back(mk(0, 0, 0, 0, 0));
			end
			CMD_STOP: begin
				if (alloc_m[id] && run_m[id]) begin
					unlink(id);
					run_m[id] = 0;
				end
				r.push_back(mk(0, 0, 0, 0, 0));
			end
			CMD_DELETE: begin
				if (alloc_m[id]) begin
					unlink(id);
					run_m[id] = 0;
					alloc_m[id] = 0;
				end
				r.push_back(mk(0, 0, 0, 0, 0));
			end
			CMD_SET: begin
				if (alloc_m[id]) begin
					if (run_m[id]) unlink(id);
					cnt_m[id] = cv; rld_m[id] = rv;
					if (run_m[id]) link(id);
				end
				r.push_back(mk(0, 0, 0, 0, 0));
			end
			CMD_READ: r.push_back(mk(0, 0, 0, cnt_m[id], 0));
			CMD_TICK: begin
				if (list_len > 0 && cnt_m[order_m[0]] > 0) cnt_m[order_m[0]]--;
				while (list_len > 0 && r.size() < RESULT_CAP && cnt_m[order_m[0]] == 0) begin
					h = order_m[0];
					unlink(h);
					if (kind_m[h]) begin
						cnt_m[h] = rld_m[h];
						link(h);
					end else run_m[h] = 0;
					r.push_back(mk(0, 3'(h), 1, 0, 0));
				end
				if (r.size() == 0) r.push_back(mk(0, 0, 0, 0, 0));
			end
			default: r.push_back(mk(0, 0, 0, 0, 0));
		endcase
		r[r.size()-1].last = 1;
		foreach (r[k]) pending_q.push_back(r[k]);
	endtask

	// one command transaction; tvalid stays up until the next idle or command
	task automatic send_cmd(cmd_t c, logic [2:0] id, logic kd, logic [31:0] cv,
			logic [31:0] rv);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= c;
		s_tdata <= {4'd0, rv, cv, kd, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// receiver: random stall, compare against oldest expectation
	always @(posedge clk) begin
		tres_t got, w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = mk(m_tdata[0], m_tdata[3:1], m_tdata[4], m_tdata[36:5], m_tlast);
				seen_results++;
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					errors++;
				end else begin
					w = pending_q.pop_front();
					if (got !== w) begin
						$display("%0t: mismatch, expected %h, actual %h", $time, w, got);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	trow_t rows [$];

	task automatic row(cmd_t c, logic [2:0] id, logic kd, logic [31:0] cv, logic [31:0] rv,
			logic chk = 0, tres_t w = '0);
		trow_t t;
		t.cmd = c; t.id = id; t.kind = kd; t.cnt = cv; t.rld = rv; t.chk = chk; t.want = w;
		rows.push_back(t);
	endtask

	task automatic run_phase(int n);
		cmd_t c;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 35) c = CMD_TICK;
			else if (sel < 47) c = CMD_CREATE;
			else if (sel < 65) c = CMD_START;
			else if (sel < 72) c = CMD_STOP;
			else if (sel < 78) c = CMD_DELETE;
			else if (sel < 86) c = CMD_SET;
			else if (sel < 97) c = CMD_READ;
			else c = cmd_t'(3'd7);
			begin
				logic [2:0] id;
				logic kd;
				logic [31:0] cv, rv;
				id = 3'($urandom_range(7));
				kd = 1'($urandom_range(1));
				cv = ($urandom_range(9) == 0) ? $urandom : $urandom_range(6);
				rv = ($urandom_range(9) == 0) ? $urandom : $urandom_range(5);
				predict_timers(c, id, kd, cv, rv);
				send_cmd(c, id, kd, cv, rv);
			end
		end
	endtask

	initial begin
		s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0; arst_n = 0;
		alloc_m = 0; kind_m = 0; run_m = 0; listed_m = 0; list_len = 0;
		for (int i = 0; i < NT; i++) begin
			cnt_m[i] = 0; rld_m[i] = 0; order_m[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table
		row(CMD_READ, 3'd7, 0, 0, 0, 1, mk(0, 0, 0, 0, 1));
		row(CMD_TICK, 3'd0, 0, 0, 0, 1, mk(0, 0, 0, 0, 1));
		row(CMD_START, 3'd3, 0, 0, 0, 1, mk(0, 0, 0, 0, 1));
		row(CMD_CREATE, 3'd0, 0, 32'd2, 32'd0, 1, mk(0, 0, 0, 0, 1));
		row(CMD_CREATE, 3'd7, 1, 32'd3, 32'd2, 1, mk(0, 1, 0, 0, 1));
		row(CMD_CREATE, 3'd0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, mk(0, 2, 0, 0, 1));
		row(CMD_CREATE, 3'd0, 0, 32'd0, 32'd0, 1, mk(0, 3, 0, 0, 1));
		for (int i = 4; i < 8; i++) row(CMD_CREATE, 3'd0, 1, 32'd1, 32'd0);
		row(CMD_CREATE, 3'd0, 0, 0, 0, 1, mk(1, 0, 0, 0, 1));
		row(CMD_START, 3'd0, 0, 0, 0);
		row(CMD_START, 3'd1, 0, 0, 0);
		row(CMD_START, 3'd2, 0, 0, 0);
		row(CMD_START, 3'd3, 0, 0, 0);    // zero count: runs, not listed
		row(CMD_STOP, 3'd3, 0, 0, 0);     // running but unlisted
		row(CMD_READ, 3'd1, 0, 0, 0);
		for (int i = 4; i < 8; i++) row(CMD_START, i[2:0], 0, 0, 0);
		row(CMD_TICK, 3'd0, 0, 0, 0);     // many expire at once
		row(CMD_TICK, 3'd0, 0, 0, 0);
		row(CMD_SET, 3'd1, 0, 32'd5, 32'd1);
		row(CMD_DELETE, 3'd2, 0, 0, 0);
		row(cmd_t'(3'd7), 3'd0, 0, 0, 0, 1, mk(0, 0, 0, 0, 1));
		row(CMD_TICK, 3'd0, 0, 0, 0);
		foreach (rows[i]) begin
			if (rows[i].chk) begin
				trow_t t;
				t = rows[i];
				predict_timers(t.cmd, t.id, t.kind, t.cnt, t.rld);
				pending_q[pending_q.size()-1] = t.want;
			end else predict_timers(rows[i].cmd, rows[i].id, rows[i].kind, rows[i].cnt,
				rows[i].rld);
			send_cmd(rows[i].cmd, rows[i].id, rows[i].kind, rows[i].cnt, rows[i].rld);
		end

		run_phase(70);
		send_idle = 55; recv_idle = 7;
		run_phase(70);
		send_idle = 0; recv_idle = 0;
		run_phase(62);
		s_tvalid <= 0;

		while (pending_q.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("delta_list_timer_manager_test OK");
		end else begin
			$display("delta_list_timer_manager_test NOT OK");
		end
		$finish;
	end

endmodule
